// ===== hw/rtl/scalar_kalman_filter_defines.svh =====
// Assertion macros used by the scalar Kalman filter RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef SCALAR_KALMAN_FILTER_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define SKF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define SKF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/skf_pkg.sv =====
// Types, widths and helpers for the scalar Kalman filter.
// No dependencies; used by scalar_kalman_filter.
package skf_pkg;

    localparam int DATA_W    = 32;   // signed Q16.16 word
    localparam int VAR_W     = 31;   // unsigned variance word
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = 66;   // 33 x 33 signed product
    localparam int RND_W     = PROD_W - FRAC_BITS;
    localparam int DEN_W     = 32;   // pt + r never exceeds 2^32 - 2
    localparam int QUO_W     = 32;
    localparam int CNT_W     = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;
    localparam logic [VAR_W-1:0]  V_MAX   = 31'h7FFF_FFFF;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_PHI2,
        ST_MUL_AT,
        ST_MUL_PT,
        ST_VT,
        ST_MUL_PV,
        ST_LOAD_PV,
        ST_DIV_PV,
        ST_MEAN,
        ST_DIV_PP,
        ST_VAR,
        ST_PUSH
    } skf_state_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AR_COEF     = 3'd0,
        CFG_OBS_OFFSET  = 3'd1,
        CFG_OBS_NOISE   = 3'd2,
        CFG_STATE_NOISE = 3'd3,
        CFG_PRIOR_MEAN  = 3'd4,
        CFG_PRIOR_VAR   = 3'd5
    } skf_cfg_t;

    // Round a product to nearest at the binary point, ties toward +infinity
    function automatic logic signed [RND_W-1:0] fx_round(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = p + (PROD_W'(1) <<< (FRAC_BITS - 1));
        return $signed(s[PROD_W-1:FRAC_BITS]);
    endfunction

endpackage

// ===== hw/rtl/scalar_kalman_filter.sv =====
// Scalar Kalman filter, top level: sequencer, shared multiplier and shared divider.
// Depends on skf_pkg and scalar_kalman_filter_defines.svh.
// in_ready is high only in idle; it falls once a word is accepted and rises when the
// sequencer returns to idle, so no new word is taken before the last one is through.
// A last result waits in ST_PUSH for the output register. Reset clears sequencer, state
// and out valid. Per word: the radix-2 divider twice, five steps on one 33x33 multiplier.
`include "scalar_kalman_filter_defines.svh"

module scalar_kalman_filter
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [skf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [skf_pkg::DATA_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [skf_pkg::DATA_W-1:0]    observation,
    input  logic                                 first_sample,
    input  logic                                 last_sample,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [skf_pkg::DATA_W-1:0]    filtered_mean,
    output logic [skf_pkg::VAR_W-1:0]            filtered_var,
    output logic                                 saturated
);

    // Sequencer
    skf_pkg::skf_state_t state_reg, state_next;

    // Configuration registers
    logic signed [skf_pkg::DATA_W-1:0] phi_reg, phi_next;
    logic signed [skf_pkg::DATA_W-1:0] gamma_reg, gamma_next;
    logic [skf_pkg::VAR_W-1:0]         r_reg, r_next;
    logic [skf_pkg::VAR_W-1:0]         q_reg, q_next;
    logic signed [skf_pkg::DATA_W-1:0] m0_reg, m0_next;
    logic [skf_pkg::VAR_W-1:0]         p0_reg, p0_next;

    // Filter state and working registers
    logic signed [skf_pkg::DATA_W-1:0] mean_reg, mean_next;
    logic [skf_pkg::VAR_W-1:0]         var_reg, var_next;
    logic                              sat_reg, sat_next;
    logic                              last_reg, last_next;
    logic signed [skf_pkg::DATA_W-1:0] y_reg, y_next;
    logic [skf_pkg::VAR_W-1:0]         phi2_reg, phi2_next;
    logic signed [skf_pkg::DATA_W-1:0] at_reg, at_next;
    logic [skf_pkg::VAR_W-1:0]         pt_reg, pt_next;
    logic signed [skf_pkg::DATA_W-1:0] vt_reg, vt_next;
    logic [skf_pkg::DEN_W-1:0]         den_reg, den_next;
    logic                              neg_reg, neg_next;
    logic signed [skf_pkg::PROD_W-1:0] prod_reg, prod_next;

    // Divider registers
    logic [skf_pkg::DEN_W-1:0] rem_reg, rem_next;
    logic [skf_pkg::QUO_W-1:0] quo_reg, quo_next;
    logic [skf_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    // Output word registers
    logic                              out_valid_reg, out_valid_next;
    logic signed [skf_pkg::DATA_W-1:0] out_mean_reg, out_mean_next;
    logic [skf_pkg::VAR_W-1:0]         out_var_reg, out_var_next;
    logic                              out_sat_reg, out_sat_next;

    // Sequencer outputs
    logic mul_en;
    logic div_load;
    logic div_step;
    logic signed [skf_pkg::DATA_W:0]   mul_a;
    logic signed [skf_pkg::DATA_W:0]   mul_b;
    logic signed [skf_pkg::PROD_W-1:0] mul_p;

    // Datapath intermediates
    logic                              in_fire;
    logic                              push_fire;
    logic signed [skf_pkg::RND_W-1:0]  rnd;
    logic                              rnd_hi;
    logic                              rnd_lo;
    logic signed [skf_pkg::RND_W:0]    pt_sum;
    logic signed [skf_pkg::DATA_W:0]   y_full;
    logic signed [skf_pkg::DATA_W:0]   vt_full;
    logic signed [skf_pkg::PROD_W-1:0] prod_mag;
    logic [skf_pkg::PROD_W-4:0]        num;
    logic [skf_pkg::DEN_W:0]           div_shift;
    logic [skf_pkg::DEN_W+1:0]         div_diff;
    logic                              div_ge;
    logic                              den_zero;
    logic [skf_pkg::QUO_W-1:0]         q_eff;
    logic signed [skf_pkg::DATA_W+1:0] q_signed;
    logic signed [skf_pkg::DATA_W+1:0] m_sum;
    logic                              m_ovf;
    logic signed [skf_pkg::DATA_W:0]   p_diff;

    // Check conditions
    logic                              div_run;
    logic                              var_step;
    logic                              push_state;
    logic                              push_stall;

    // Shared multiplier
    assign mul_p = mul_a * mul_b;

    assign in_fire   = in_valid && in_ready;
    assign push_fire = (state_reg == skf_pkg::ST_PUSH) && (!out_valid_reg || out_ready);
    assign den_zero  = (den_reg == '0);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            skf_pkg::ST_IDLE:     if (in_valid) state_next = skf_pkg::ST_MUL_PHI2;
            skf_pkg::ST_MUL_PHI2: state_next = skf_pkg::ST_MUL_AT;
            skf_pkg::ST_MUL_AT:   state_next = skf_pkg::ST_MUL_PT;
            skf_pkg::ST_MUL_PT:   state_next = skf_pkg::ST_VT;
            skf_pkg::ST_VT:       state_next = skf_pkg::ST_MUL_PV;
            skf_pkg::ST_MUL_PV:   state_next = skf_pkg::ST_LOAD_PV;
            skf_pkg::ST_LOAD_PV:  state_next = skf_pkg::ST_DIV_PV;
            skf_pkg::ST_DIV_PV:   if (cnt_reg == '0) state_next = skf_pkg::ST_MEAN;
            skf_pkg::ST_MEAN:     state_next = skf_pkg::ST_DIV_PP;
            skf_pkg::ST_DIV_PP:   if (cnt_reg == '0) state_next = skf_pkg::ST_VAR;
            skf_pkg::ST_VAR:
                state_next = last_reg ? skf_pkg::ST_PUSH : skf_pkg::ST_IDLE;
            skf_pkg::ST_PUSH:     if (push_fire) state_next = skf_pkg::ST_IDLE;
            default:              state_next = skf_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, multiplier operands, divider control
    always_comb
    begin
        in_ready = 1'b0;
        mul_en   = 1'b0;
        div_load = 1'b0;
        div_step = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        unique case (state_reg)
            skf_pkg::ST_IDLE:
                in_ready = 1'b1;
            skf_pkg::ST_MUL_PHI2:
            begin
                mul_en = 1'b1;
                mul_a  = {phi_reg[skf_pkg::DATA_W-1], phi_reg};
                mul_b  = {phi_reg[skf_pkg::DATA_W-1], phi_reg};
            end
            skf_pkg::ST_MUL_AT:
            begin
                mul_en = 1'b1;
                mul_a  = {phi_reg[skf_pkg::DATA_W-1], phi_reg};
                mul_b  = {mean_reg[skf_pkg::DATA_W-1], mean_reg};
            end
            skf_pkg::ST_MUL_PT:
            begin
                mul_en = 1'b1;
                mul_a  = $signed({2'b00, phi2_reg});
                mul_b  = $signed({2'b00, var_reg});
            end
            skf_pkg::ST_MUL_PV:
            begin
                mul_en = 1'b1;
                mul_a  = $signed({2'b00, pt_reg});
                mul_b  = {vt_reg[skf_pkg::DATA_W-1], vt_reg};
            end
            skf_pkg::ST_LOAD_PV:
            begin
                mul_en   = 1'b1;
                div_load = 1'b1;
                mul_a    = $signed({2'b00, pt_reg});
                mul_b    = $signed({2'b00, pt_reg});
            end
            skf_pkg::ST_MEAN:
                div_load = 1'b1;
            skf_pkg::ST_DIV_PV, skf_pkg::ST_DIV_PP:
                div_step = 1'b1;
            skf_pkg::ST_VT, skf_pkg::ST_VAR, skf_pkg::ST_PUSH:
                ;
            default:
                ;
        endcase
    end

    // Configuration writes
    always_comb
    begin
        phi_next   = phi_reg;
        gamma_next = gamma_reg;
        r_next     = r_reg;
        q_next     = q_reg;
        m0_next    = m0_reg;
        p0_next    = p0_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                skf_pkg::CFG_AR_COEF:     phi_next   = $signed(cfg_data);
                skf_pkg::CFG_OBS_OFFSET:  gamma_next = $signed(cfg_data);
                skf_pkg::CFG_OBS_NOISE:   r_next     = cfg_data[skf_pkg::VAR_W-1:0];
                skf_pkg::CFG_STATE_NOISE: q_next     = cfg_data[skf_pkg::VAR_W-1:0];
                skf_pkg::CFG_PRIOR_MEAN:  m0_next    = $signed(cfg_data);
                skf_pkg::CFG_PRIOR_VAR:   p0_next    = cfg_data[skf_pkg::VAR_W-1:0];
                default:                  ;
            endcase
        end
    end

    // Shared rounding of the registered product, its clamp flags, and the sums and differences
    always_comb
    begin
        rnd    = skf_pkg::fx_round(prod_reg);
        rnd_hi = !rnd[skf_pkg::RND_W-1] && (|rnd[skf_pkg::RND_W-2:skf_pkg::DATA_W-1]);
        rnd_lo = rnd[skf_pkg::RND_W-1] && !(&rnd[skf_pkg::RND_W-2:skf_pkg::DATA_W-1]);
        pt_sum = {rnd[skf_pkg::RND_W-1], rnd}
               + $signed({{(skf_pkg::RND_W-skf_pkg::VAR_W+1){1'b0}}, q_reg});
        y_full  = {observation[skf_pkg::DATA_W-1], observation}
                - {gamma_reg[skf_pkg::DATA_W-1], gamma_reg};
        vt_full = {y_reg[skf_pkg::DATA_W-1], y_reg} - {at_reg[skf_pkg::DATA_W-1], at_reg};
    end

    // Divider: load magnitude plus half divisor, then one quotient bit per cycle
    always_comb
    begin
        prod_mag  = prod_reg[skf_pkg::PROD_W-1] ? -prod_reg : prod_reg;
        num       = prod_mag[skf_pkg::PROD_W-4:0]
                  + {{(skf_pkg::PROD_W-2-skf_pkg::DEN_W){1'b0}},
                     den_reg[skf_pkg::DEN_W-1:1]};
        div_shift = {rem_reg, quo_reg[skf_pkg::QUO_W-1]};
        div_diff  = {1'b0, div_shift} - {2'b00, den_reg};
        div_ge    = !div_diff[skf_pkg::DEN_W+1];
        q_eff     = den_zero ? '0 : quo_reg;
        q_signed  = neg_reg ? -$signed({2'b00, q_eff}) : $signed({2'b00, q_eff});
        m_sum     = {{2{at_reg[skf_pkg::DATA_W-1]}}, at_reg} + q_signed;
        m_ovf     = !((m_sum[skf_pkg::DATA_W+1:skf_pkg::DATA_W-1] == 3'b000)
                   || (m_sum[skf_pkg::DATA_W+1:skf_pkg::DATA_W-1] == 3'b111));
        p_diff    = $signed({2'b00, pt_reg}) - $signed({1'b0, q_eff});
    end

    // Datapath register updates
    always_comb
    begin
        mean_next      = mean_reg;
        var_next       = var_reg;
        sat_next       = sat_reg;
        last_next      = last_reg;
        y_next         = y_reg;
        phi2_next      = phi2_reg;
        at_next        = at_reg;
        pt_next        = pt_reg;
        vt_next        = vt_reg;
        den_next       = den_reg;
        neg_next       = neg_reg;
        prod_next      = mul_en ? mul_p : prod_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_mean_next  = out_mean_reg;
        out_var_next   = out_var_reg;
        out_sat_next   = out_sat_reg;

        // Accept a word: take the prior on a series start, remove the offset
        if (in_fire)
        begin
            last_next = last_sample;
            if (first_sample)
            begin
                mean_next = m0_reg;
                var_next  = p0_reg;
            end
            if (y_full[skf_pkg::DATA_W] != y_full[skf_pkg::DATA_W-1])
            begin
                y_next   = y_full[skf_pkg::DATA_W] ? skf_pkg::S32_MIN : skf_pkg::S32_MAX;
                sat_next = 1'b1;
            end
            else
            begin
                y_next   = y_full[skf_pkg::DATA_W-1:0];
                sat_next = first_sample ? 1'b0 : sat_reg;
            end
        end

        // phi squared, clamped to the variance range
        if (state_reg == skf_pkg::ST_MUL_AT)
        begin
            if (rnd_lo || rnd[skf_pkg::RND_W-1])
            begin
                phi2_next = '0;
                sat_next  = 1'b1;
            end
            else if (rnd_hi)
            begin
                phi2_next = skf_pkg::V_MAX;
                sat_next  = 1'b1;
            end
            else
                phi2_next = rnd[skf_pkg::VAR_W-1:0];
        end

        // Predicted mean
        if (state_reg == skf_pkg::ST_MUL_PT)
        begin
            if (rnd_hi || rnd_lo)
            begin
                at_next  = rnd_hi ? skf_pkg::S32_MAX : skf_pkg::S32_MIN;
                sat_next = 1'b1;
            end
            else
                at_next = rnd[skf_pkg::DATA_W-1:0];
        end

        // Predicted variance and innovation
        if (state_reg == skf_pkg::ST_VT)
        begin
            if (pt_sum[skf_pkg::RND_W])
            begin
                pt_next  = '0;
                sat_next = 1'b1;
            end
            else if (|pt_sum[skf_pkg::RND_W-1:skf_pkg::VAR_W])
            begin
                pt_next  = skf_pkg::V_MAX;
                sat_next = 1'b1;
            end
            else
                pt_next = pt_sum[skf_pkg::VAR_W-1:0];
            if (vt_full[skf_pkg::DATA_W] != vt_full[skf_pkg::DATA_W-1])
            begin
                vt_next  = vt_full[skf_pkg::DATA_W] ? skf_pkg::S32_MIN : skf_pkg::S32_MAX;
                sat_next = 1'b1;
            end
            else
                vt_next = vt_full[skf_pkg::DATA_W-1:0];
        end

        // Denominator of the gain
        if (state_reg == skf_pkg::ST_MUL_PV)
            den_next = {1'b0, pt_reg} + {1'b0, r_reg};

        // Load the divider from the registered product
        if (div_load)
        begin
            rem_next = {1'b0, num[skf_pkg::PROD_W-4:skf_pkg::QUO_W]};
            quo_next = num[skf_pkg::QUO_W-1:0];
            cnt_next = skf_pkg::CNT_W'(skf_pkg::QUO_W - 1);
        end
        if (state_reg == skf_pkg::ST_LOAD_PV)
            neg_next = prod_reg[skf_pkg::PROD_W-1];

        // Advance the divider by one quotient bit
        if (div_step)
        begin
            rem_next = div_ge ? div_diff[skf_pkg::DEN_W-1:0] : div_shift[skf_pkg::DEN_W-1:0];
            quo_next = {quo_reg[skf_pkg::QUO_W-2:0], div_ge};
            cnt_next = cnt_reg - 1'b1;
        end

        // Corrected mean
        if (state_reg == skf_pkg::ST_MEAN)
        begin
            if (m_ovf)
            begin
                mean_next = m_sum[skf_pkg::DATA_W+1] ? skf_pkg::S32_MIN : skf_pkg::S32_MAX;
                sat_next  = 1'b1;
            end
            else
                mean_next = m_sum[skf_pkg::DATA_W-1:0];
        end

        // Corrected variance, floored at zero
        if (state_reg == skf_pkg::ST_VAR)
            var_next = p_diff[skf_pkg::DATA_W] ? '0 : p_diff[skf_pkg::VAR_W-1:0];

        // Hand the result word to the output register
        if (push_fire)
        begin
            out_valid_next = 1'b1;
            out_mean_next  = mean_reg;
            out_var_next   = var_reg;
            out_sat_next   = sat_reg;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= skf_pkg::ST_IDLE;
            phi_reg       <= '0;
            gamma_reg     <= '0;
            r_reg         <= skf_pkg::VAR_W'(65536);
            q_reg         <= skf_pkg::VAR_W'(65536);
            m0_reg        <= '0;
            p0_reg        <= skf_pkg::VAR_W'(65536);
            mean_reg      <= '0;
            var_reg       <= '0;
            sat_reg       <= 1'b0;
            last_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phi_reg       <= phi_next;
            gamma_reg     <= gamma_next;
            r_reg         <= r_next;
            q_reg         <= q_next;
            m0_reg        <= m0_next;
            p0_reg        <= p0_next;
            mean_reg      <= mean_next;
            var_reg       <= var_next;
            sat_reg       <= sat_next;
            last_reg      <= last_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        y_reg        <= y_next;
        phi2_reg     <= phi2_next;
        at_reg       <= at_next;
        pt_reg       <= pt_next;
        vt_reg       <= vt_next;
        den_reg      <= den_next;
        neg_reg      <= neg_next;
        prod_reg     <= prod_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        out_mean_reg <= out_mean_next;
        out_var_reg  <= out_var_next;
        out_sat_reg  <= out_sat_next;
    end

    assign out_valid     = out_valid_reg;
    assign filtered_mean = out_mean_reg;
    assign filtered_var  = out_var_reg;
    assign saturated     = out_sat_reg;

    // Conditions watched by the checks below
    assign div_run    = div_step && !den_zero;
    assign var_step   = (state_reg == skf_pkg::ST_VAR);
    assign push_state = (state_reg == skf_pkg::ST_PUSH);
    assign push_stall = push_state && out_valid_reg && !out_ready;

    // Checks on the sequencer and the divider
    `SKF_ASSERT_NXT(a_busy_after_accept, in_fire, !in_ready, "accepted a word while busy")
    `SKF_ASSERT_IMP(a_rem_below_den, div_run, rem_reg < den_reg, "remainder above divisor")
    `SKF_ASSERT_IMP(a_var_within_pt, var_step, var_next <= pt_reg, "variance above prediction")
    `SKF_ASSERT_NXT(a_push_waits, push_stall, push_state, "result word dropped while stalled")
    `SKF_ASSERT_NXT(a_push_held, push_stall, $stable(out_mean_reg), "result word overwritten")

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for scalar_kalman_filter: directed and random observation series.
// An in-bench Q16.16 filter predicts each result; depends on skf_pkg and the RTL only.
`timescale 1ns / 100ps

module tb;

    localparam longint MEAN_HI    = 64'sd2147483647;
    localparam longint MEAN_LO    = -64'sd2147483648;
    localparam longint VAR_HI     = 64'sd2147483647;
    localparam longint CYCLE_CAP  = 1000000;
    localparam int     DRAIN_WAIT = 100;

    typedef struct packed {
        logic [31:0] phi;
        logic [31:0] gamma;
        logic [31:0] obs_var;
        logic [31:0] state_var;
        logic [31:0] mean0;
        logic [31:0] var0;
    } filter_cfg_t;

    typedef struct packed {
        logic [31:0] mean;
        logic [30:0] variance;
        logic        sat;
    } estimate_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic [skf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [31:0] observation = '0;
    logic               first_sample = 1'b0;
    logic               last_sample = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] filtered_mean;
    logic [30:0]        filtered_var;
    logic               saturated;

    // filter registers and running estimate as the block should hold them
    longint    ar_coef, obs_offset_q, obs_noise_q, state_noise_q, prior_mean_q, prior_var_q;
    longint    est_mean, est_var;
    bit        est_sat;
    estimate_t estimate_q[$];

    int     mismatches = 0;
    int     words_sent = 0;
    int     max_gap = 6;
    int     max_stall = 6;
    int     holdoff_cycles = 0;
    longint cycle_count = 0;

    scalar_kalman_filter uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .observation   (observation),
        .first_sample  (first_sample),
        .last_sample   (last_sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .filtered_mean (filtered_mean),
        .filtered_var  (filtered_var),
        .saturated     (saturated)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic longint clip(input longint v, input longint lo, input longint hi,
                                    inout bit hit);
        if (v < lo)
        begin
            hit = 1'b1;
            return lo;
        end
        if (v > hi)
        begin
            hit = 1'b1;
            return hi;
        end
        return v;
    endfunction

    // product rounded to nearest at the binary point, ties upwards
    function automatic longint qmul(input longint a, input longint b);
        return (a * b + 64'sd32768) >>> skf_pkg::FRAC_BITS;
    endfunction

    // quotient rounded to nearest, ties away from zero; den > 0
    function automatic longint round_div(input longint num, input longint den);
        longint mag;
        longint quo;
        mag = (num < 0) ? -num : num;
        quo = (mag + den / 2) / den;
        return (num < 0) ? -quo : quo;
    endfunction

    // advance the estimate by one observation; queue the result on a last word
    function automatic void filter_step(input logic signed [31:0] obs, input bit first,
                                        input bit last);
        longint    m_prev, p_prev, phi2, at, pt, y, vt, den, m, p;
        bit        sat;
        estimate_t res;
        if (first)
        begin
            m_prev = prior_mean_q;
            p_prev = prior_var_q;
            sat    = 1'b0;
        end
        else
        begin
            m_prev = est_mean;
            p_prev = est_var;
            sat    = est_sat;
        end
        phi2 = clip(qmul(ar_coef, ar_coef), 0, VAR_HI, sat);
        at   = clip(qmul(ar_coef, m_prev), MEAN_LO, MEAN_HI, sat);
        pt   = clip(qmul(phi2, p_prev) + state_noise_q, 0, VAR_HI, sat);
        y    = clip(longint'(obs) - obs_offset_q, MEAN_LO, MEAN_HI, sat);
        vt   = clip(y - at, MEAN_LO, MEAN_HI, sat);
        den  = pt + obs_noise_q;
        // a zero denominator skips the correction
        if (den > 0)
        begin
            m = clip(at + round_div(pt * vt, den), MEAN_LO, MEAN_HI, sat);
            p = pt - round_div(pt * pt, den);
            if (p < 0)
                p = 0;
        end
        else
        begin
            m = at;
            p = pt;
        end
        est_mean = m;
        est_var  = p;
        est_sat  = sat;
        if (last)
        begin
            res.mean     = m[31:0];
            res.variance = p[30:0];
            res.sat      = sat;
            estimate_q.push_back(res);
        end
    endfunction

    // ---------------------------------------------------------------- drivers

    // write one register; the caller lowers cfg_write after the last one
    task automatic write_reg(input skf_pkg::skf_cfg_t idx, input logic [31:0] d);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        case (idx)
            skf_pkg::CFG_AR_COEF:     ar_coef       = longint'($signed(d));
            skf_pkg::CFG_OBS_OFFSET:  obs_offset_q  = longint'($signed(d));
            skf_pkg::CFG_OBS_NOISE:   obs_noise_q   = longint'(d[30:0]);
            skf_pkg::CFG_STATE_NOISE: state_noise_q = longint'(d[30:0]);
            skf_pkg::CFG_PRIOR_MEAN:  prior_mean_q  = longint'($signed(d));
            skf_pkg::CFG_PRIOR_VAR:   prior_var_q   = longint'(d[30:0]);
            default: ;
        endcase
    endtask

    task automatic load_config(input filter_cfg_t c);
        write_reg(skf_pkg::CFG_AR_COEF, c.phi);
        write_reg(skf_pkg::CFG_OBS_OFFSET, c.gamma);
        write_reg(skf_pkg::CFG_OBS_NOISE, c.obs_var);
        write_reg(skf_pkg::CFG_STATE_NOISE, c.state_var);
        write_reg(skf_pkg::CFG_PRIOR_MEAN, c.mean0);
        write_reg(skf_pkg::CFG_PRIOR_VAR, c.var0);
        cfg_write <= 1'b0;
    endtask

    // offer one word after a random gap; valid is left high until the next call decides
    task automatic send_sample(input logic signed [31:0] obs, input bit first, input bit last);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        observation  <= obs;
        first_sample <= first;
        last_sample  <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        filter_step(obs, first, last);
        words_sent++;
    endtask

    // hold the input until every expected result has come back
    task automatic wait_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (estimate_q.size() != 0)
            @(posedge clk);
    endtask

    // drain, then let a trailing word with no result finish before a register write
    task automatic settle();
        wait_results();
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // ---------------------------------------------------------------- result checker

    task automatic check_result();
        estimate_t want;
        if (estimate_q.size() == 0)
        begin
            $error("result with none expected: filtered_mean %h", filtered_mean);
            mismatches++;
        end
        else
        begin
            want = estimate_q.pop_front();
            if (filtered_mean !== want.mean)
            begin
                $error("filtered_mean: expected %h, got %h", want.mean, filtered_mean);
                mismatches++;
            end
            if (filtered_var !== want.variance)
            begin
                $error("filtered_var: expected %h, got %h", want.variance, filtered_var);
                mismatches++;
            end
            if (saturated !== want.sat)
            begin
                $error("saturated: expected %b, got %b", want.sat, saturated);
                mismatches++;
            end
        end
    endtask

    // accept results, stall at random, and hold off on request
    initial
    begin : result_sink
        int stall;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            stall = 0;
            if (out_valid && out_ready)
            begin
                check_result();
                stall = $urandom_range(0, max_stall);
            end
            if (holdoff_cycles > 0)
            begin
                stall = holdoff_cycles;
                holdoff_cycles = 0;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- random values

    function automatic logic [31:0] rand_signed(input int span);
        int v;
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return $urandom;
            default:
            begin
                v = int'($urandom_range(0, 2 * span)) - span;
                return v;
            end
        endcase
    endfunction

    function automatic logic [31:0] rand_variance(input int span);
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_FFFF;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return $urandom;
            default: return $urandom_range(0, span);
        endcase
    endfunction

    function automatic filter_cfg_t rand_cfg();
        filter_cfg_t c;
        c.phi       = rand_signed(80000);
        c.gamma     = rand_signed(1 << 20);
        c.obs_var   = rand_variance(1 << 20);
        c.state_var = rand_variance(1 << 20);
        c.mean0     = rand_signed(1 << 22);
        c.var0      = rand_variance(1 << 20);
        return c;
    endfunction

    function automatic logic [31:0] rand_obs();
        int v;
        case ($urandom_range(0, 7))
            0: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1, 2: return $urandom;
            default:
            begin
                v = int'($urandom_range(0, 1 << 23)) - (1 << 22);
                return v;
            end
        endcase
    endfunction

    // mostly well-formed series with random content, some stray flags
    task automatic run_series_mix(input int count);
        int start;
        int len;
        int i;
        start = words_sent;
        while (words_sent - start < count)
        begin
            if ($urandom_range(0, 9) == 0)
                send_sample(rand_obs(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else
            begin
                len = $urandom_range(1, 8);
                for (i = 0; i < len; i++)
                    send_sample(rand_obs(), i == 0, i == len - 1);
            end
            if ($urandom_range(0, 15) == 0)
                wait_results();
        end
    endtask

    // ---------------------------------------------------------------- tests

    // reset registers, including a series that never saw a first word
    task automatic test_reset_state();
        send_sample(32'sh0001_0000, 1'b0, 1'b1);
        send_sample(32'sh7FFF_FFFF, 1'b1, 1'b1);
        send_sample(32'sh8000_0000, 1'b1, 1'b0);
        send_sample(32'sh0000_0000, 1'b0, 1'b0);
        send_sample(-32'sd1, 1'b0, 1'b1);
    endtask

    // registers and observations at their limits, clamping in the prediction and innovation steps
    task automatic test_saturation();
        settle();
        load_config('{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
        send_sample(32'sh7FFF_FFFF, 1'b1, 1'b0);
        send_sample(32'sh8000_0000, 1'b0, 1'b1);
        send_sample(32'sh0000_0000, 1'b1, 1'b1);
        settle();
        load_config('{32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                      32'h0, 32'h8000_0000, 32'h0});
        send_sample(32'sh8000_0000, 1'b1, 1'b1);
        send_sample(32'sh7FFF_FFFF, 1'b1, 1'b0);
        send_sample(32'sd12345, 1'b0, 1'b1);
    endtask

    // zero predicted variance and zero observation noise: correction is skipped
    task automatic test_zero_denominator();
        settle();
        load_config('{32'h0, 32'h0, 32'h0, 32'h0, 32'h0004_0000, 32'h0123_4567});
        send_sample(32'sh0003_0000, 1'b1, 1'b1);
        send_sample(-32'sd5, 1'b1, 1'b0);
        send_sample(32'sd7, 1'b0, 1'b1);
    endtask

    // an ordinary series, restarted from the prior part way through
    task automatic test_ordinary_series();
        settle();
        load_config('{32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                      32'h0000_0100, 32'h0005_0000, 32'h0002_0000});
        send_sample(32'sh0006_0000, 1'b1, 1'b0);
        send_sample(32'sh0005_8000, 1'b0, 1'b0);
        send_sample(32'sh0007_0000, 1'b1, 1'b0);
        send_sample(-32'sh0001_0000, 1'b0, 1'b0);
        send_sample(32'sh0004_0000, 1'b0, 1'b0);
        send_sample(32'sh0004_4000, 1'b0, 1'b1);
    endtask

    task automatic test_random_settings();
        repeat (5)
        begin
            settle();
            load_config(rand_cfg());
            run_series_mix(160);
        end
    endtask

    // words and results with no random gaps or stalls on either side
    task automatic test_full_rate();
        settle();
        max_gap   = 0;
        max_stall = 0;
        load_config(rand_cfg());
        run_series_mix(150);
        settle();
        max_gap   = 6;
        max_stall = 6;
    endtask

    // hold the output off so the block backs up into its input
    task automatic test_output_backpressure();
        settle();
        load_config('{32'h0000_C000, 32'h0000_8000, 32'h0002_0000,
                      32'h0000_4000, 32'h0001_0000, 32'h0001_0000});
        holdoff_cycles = 400;
        repeat (8)
            send_sample(rand_obs(), 1'b1, 1'b1);
        wait_results();
        repeat (4)
            send_sample(rand_obs(), 1'b0, 1'($urandom_range(0, 1)));
        send_sample(rand_obs(), 1'b0, 1'b1);
    endtask

    initial
    begin : run_tests
        // reset values of the registers and the filter state
        ar_coef       = 0;
        obs_offset_q  = 0;
        obs_noise_q   = 65536;
        state_noise_q = 65536;
        prior_mean_q  = 0;
        prior_var_q   = 65536;
        est_mean      = 0;
        est_var       = 0;
        est_sat       = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_saturation();
        test_zero_denominator();
        test_ordinary_series();
        test_random_settings();
        test_full_rate();
        test_output_backpressure();

        // drain and let the block go quiet
        wait_results();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (estimate_q.size() != 0)
        begin
            $error("%0d results never arrived", estimate_q.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== scalar_kalman_filter.f =====
+incdir+hw/rtl
hw/rtl/skf_pkg.sv
hw/rtl/scalar_kalman_filter.sv
tb/sv/tb.sv
